/* hw/rtl/eip_pkg.sv */
// ----------------------------------------------------------------------------
// eip_pkg
// Shared widths, codes, control types, curve step programs and the sine table.
// ----------------------------------------------------------------------------
package eip_pkg;

    localparam int FRAC_BITS        = 16;
    localparam int SINE_TABLE_DEPTH = 1024;

    localparam int QW  = FRAC_BITS + 1;
    localparam int PW  = FRAC_BITS + 5;
    localparam int MW  = QW + PW + 1;
    localparam int SAW = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int CW  = $clog2(FRAC_BITS);
    localparam int BW  = 32 + QW + 1;
    localparam int AW  = BW + 1;
    localparam int EW  = 25;
    localparam int DW  = 24;
    localparam int STW = 16;
    localparam int IW  = 2;

    localparam logic [QW-1:0] ONE_Q  = QW'(1) << FRAC_BITS;
    localparam logic [QW-1:0] HALF_Q = QW'(1) << (FRAC_BITS - 1);

    localparam longint unsigned PIOVER2_Q30 = 64'd1686629713;
    localparam longint unsigned Q30_HALF    = 64'd1 << 29;
    localparam longint unsigned SINE_DIV [1:9] = '{
        64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272, 64'd342
    };

    localparam logic [IW-1:0] CFG_START    = 2'd0;
    localparam logic [IW-1:0] CFG_END      = 2'd1;
    localparam logic [IW-1:0] CFG_DURATION = 2'd2;
    localparam logic [IW-1:0] CFG_CURVE    = 2'd3;

    localparam logic [3:0] MODE_LINEAR       = 4'd0;
    localparam logic [3:0] MODE_SMOOTH       = 4'd1;
    localparam logic [3:0] MODE_SMOOTHER     = 4'd2;
    localparam logic [3:0] MODE_DBL_SMOOTH   = 4'd3;
    localparam logic [3:0] MODE_DBL_SMOOTHER = 4'd4;
    localparam logic [3:0] MODE_ACCEL        = 4'd5;
    localparam logic [3:0] MODE_DECEL        = 4'd6;
    localparam logic [3:0] MODE_CUBE_ACCEL   = 4'd7;
    localparam logic [3:0] MODE_CUBE_DECEL   = 4'd8;
    localparam logic [3:0] MODE_SINE         = 4'd9;

    typedef enum logic [1:0] {
        REQ_TICK    = 2'd0,
        REQ_START   = 2'd1,
        REQ_STOP    = 2'd2,
        REQ_RESTART = 2'd3
    } t_req;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_FILL,
        OP_LATCH,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_MUL_XX,
        OP_MUL_AX,
        OP_SMOOTH,
        OP_SMOOTHER,
        OP_TAKE_A,
        OP_TAKE_B,
        OP_REFLECT,
        OP_SINE_ADDR,
        OP_SINE_LOAD,
        OP_BLEND1,
        OP_BLEND2,
        OP_COMMIT,
        OP_END
    } t_op;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic       tick_active;
        logic       el_ge_dur;
        logic       div_last;
        logic       fill_last;
        logic       out_busy;
        logic [3:0] curve_mode;
    } t_status;

    typedef logic [QW-1:0] t_sine_rom [0:SINE_TABLE_DEPTH];

    function automatic t_sine_rom build_sine();
        t_sine_rom       rom;
        longint unsigned iu;
        longint unsigned th;
        longint unsigned th2;
        longint unsigned term;
        longint unsigned pos;
        longint unsigned neg;
        longint unsigned s;
        longint unsigned e;
        for (int i = 0; i <= SINE_TABLE_DEPTH; i++) begin
            iu   = 64'(i);
            th   = PIOVER2_Q30 * iu / SINE_TABLE_DEPTH;
            th2  = (th * th) >> 30;
            term = th;
            pos  = th;
            neg  = 0;
            for (int k = 1; k <= 9; k++) begin
                term = ((term * th2) >> 30) / SINE_DIV[k];
                if (k[0]) begin
                    neg = neg + term;
                end else begin
                    pos = pos + term;
                end
            end
            s = (pos > neg) ? pos - neg : 64'd0;
            e = ((s << FRAC_BITS) + Q30_HALF) >> 30;
            if (e > 64'(ONE_Q)) begin
                e = 64'(ONE_Q);
            end
            rom[i] = QW'(e);
        end
        return rom;
    endfunction

    localparam t_sine_rom SINE_ROM = build_sine();

    function automatic t_op shape_op(input logic [3:0] mode, input logic [2:0] pc);
        t_op op;
        op = OP_END;
        unique case (mode)
            MODE_SMOOTH: begin
                unique case (pc)
                    3'd0:    op = OP_MUL_XX;
                    3'd1:    op = OP_SMOOTH;
                    default: op = OP_END;
                endcase
            end
            MODE_SMOOTHER: begin
                unique case (pc)
                    3'd0:    op = OP_MUL_XX;
                    3'd1:    op = OP_MUL_AX;
                    3'd2:    op = OP_SMOOTHER;
                    default: op = OP_END;
                endcase
            end
            MODE_DBL_SMOOTH: begin
                unique case (pc)
                    3'd0:    op = OP_MUL_XX;
                    3'd1:    op = OP_SMOOTH;
                    3'd2:    op = OP_MUL_XX;
                    3'd3:    op = OP_SMOOTH;
                    default: op = OP_END;
                endcase
            end
            MODE_DBL_SMOOTHER: begin
                unique case (pc)
                    3'd0:    op = OP_MUL_XX;
                    3'd1:    op = OP_MUL_AX;
                    3'd2:    op = OP_SMOOTHER;
                    3'd3:    op = OP_MUL_XX;
                    3'd4:    op = OP_MUL_AX;
                    3'd5:    op = OP_SMOOTHER;
                    default: op = OP_END;
                endcase
            end
            MODE_ACCEL: begin
                unique case (pc)
                    3'd0:    op = OP_MUL_XX;
                    3'd1:    op = OP_TAKE_A;
                    default: op = OP_END;
                endcase
            end
            MODE_DECEL: begin
                unique case (pc)
                    3'd0:    op = OP_REFLECT;
                    3'd1:    op = OP_MUL_XX;
                    3'd2:    op = OP_TAKE_A;
                    3'd3:    op = OP_REFLECT;
                    default: op = OP_END;
                endcase
            end
            MODE_CUBE_ACCEL: begin
                unique case (pc)
                    3'd0:    op = OP_MUL_XX;
                    3'd1:    op = OP_MUL_AX;
                    3'd2:    op = OP_TAKE_B;
                    default: op = OP_END;
                endcase
            end
            MODE_CUBE_DECEL: begin
                unique case (pc)
                    3'd0:    op = OP_REFLECT;
                    3'd1:    op = OP_MUL_XX;
                    3'd2:    op = OP_MUL_AX;
                    3'd3:    op = OP_TAKE_B;
                    3'd4:    op = OP_REFLECT;
                    default: op = OP_END;
                endcase
            end
            MODE_SINE: begin
                unique case (pc)
                    3'd0:    op = OP_SINE_ADDR;
                    3'd1:    op = OP_SINE_LOAD;
                    default: op = OP_END;
                endcase
            end
            default: op = OP_END;
        endcase
        return op;
    endfunction

endpackage

/* hw/rtl/eased_interpolator.sv */
// ----------------------------------------------------------------------------
// eased_interpolator
// One tween channel: blends start to end value along one of ten easing curves.
// ----------------------------------------------------------------------------
// Requests enter on the input channel (i_in_valid / o_in_stall) and each one
// produces exactly one result transfer on the output channel (o_out_valid /
// i_out_stall). Registers are to be written on the configuration channel only
// while the block is idle (not enforced); o_cfg_ready is always high.
// After reset the sine table is filled, one entry a cycle, through all 1025
// entries, during which o_in_stall stays high.
// A running tick goes from the transfer cycle through a setup step, the
// bit-serial progress divider (left out when the run is due to finish), the
// curve steps through the one shared multiplier, two blend multiplies and a
// commit. Start, stop, restart and a tick while stopped go from the transfer
// cycle through the setup step straight to the commit.
// One request is worked on at a time; the next is taken as soon as the
// previous result sits in the output register, even if that result has not
// yet been taken. While the receiver stalls a held result, a finished
// computation waits in the commit step and the output holds.
// ----------------------------------------------------------------------------
module eased_interpolator (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic [1:0]              i_req_type,
    input  logic [eip_pkg::STW-1:0] i_step_time,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic signed [31:0]      o_out_value,
    output logic                    o_running,
    output logic                    o_finished,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [eip_pkg::IW-1:0]  i_cfg_index,
    input  logic [31:0]             i_cfg_data
);
    import eip_pkg::*;

    t_cmd    cmd;
    t_status status;

    assign o_cfg_ready = 1'b1;

    eip_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    eip_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_req_type  (i_req_type),
        .i_step_time (i_step_time),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_value (o_out_value),
        .o_running   (o_running),
        .o_finished  (o_finished)
    );

endmodule

/* hw/rtl/eip_ram.sv */
// ----------------------------------------------------------------------------
// eip_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module eip_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/eip_datapath.sv */
// ----------------------------------------------------------------------------
// eip_datapath
// Configuration, tween state, divider, shared multiplier, sine table and blend.
// ----------------------------------------------------------------------------
module eip_datapath (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  eip_pkg::t_cmd             i_cmd,
    output eip_pkg::t_status          o_status,
    input  logic                      i_cfg_valid,
    input  logic [eip_pkg::IW-1:0]    i_cfg_index,
    input  logic [31:0]               i_cfg_data,
    input  logic [1:0]                i_req_type,
    input  logic [eip_pkg::STW-1:0]   i_step_time,
    input  logic                      i_out_stall,
    output logic                      o_out_valid,
    output logic signed [31:0]        o_out_value,
    output logic                      o_running,
    output logic                      o_finished
);
    import eip_pkg::*;

    logic signed [31:0] r_start_value;
    logic signed [31:0] r_end_value;
    logic [DW-1:0]      r_duration;
    logic [3:0]         r_curve_mode;

    logic [EW-1:0]      r_elapsed;
    logic               r_active;
    logic [31:0]        r_held;
    t_req               r_req;
    logic [STW-1:0]     r_step;

    logic [EW-1:0]      r_rem;
    logic [FRAC_BITS-1:0] r_quo;
    logic [CW-1:0]      r_cnt;
    logic [QW-1:0]      r_x;
    logic [QW-1:0]      r_a;
    logic [QW-1:0]      r_b;
    logic signed [BW-1:0] r_p;
    logic signed [AW-1:0] r_acc;
    logic [SAW-1:0]     r_fill;

    logic               r_out_valid;
    logic [31:0]        r_out_value;
    logic               r_running;
    logic               r_finished;

    logic [DW-1:0]      dur_eff;
    logic               el_ge_dur;
    logic [EW-1:0]      rem2;
    logic               rem_ge;

    logic [QW-1:0]      mul_a;
    logic [PW-1:0]      mul_b;
    logic [MW-1:0]      mul_q;
    logic [QW-1:0]      mul_c;
    logic [PW-1:0]      poly_pos;
    logic [PW-1:0]      poly_neg;
    logic [PW-1:0]      poly;
    logic [PW-1:0]      smooth_b;

    logic [QW+SAW:0]    sine_sum;
    logic [SAW-1:0]     sine_idx;
    logic [QW-1:0]      sine_rdata;

    logic signed [QW:0] v_s;
    logic signed [QW:0] w_s;
    logic signed [BW-1:0] prod_end;
    logic signed [BW-1:0] prod_start;
    logic [AW-1:0]      acc_sum;
    logic [31:0]        blend_val;

    logic               n_active;
    logic [EW-1:0]      n_elapsed;
    logic [31:0]        n_held;
    logic               n_fin;
    logic               take_out;

    assign dur_eff   = (r_duration == '0) ? DW'(1) : r_duration;
    assign el_ge_dur = r_elapsed >= EW'(dur_eff);
    assign rem2      = {r_rem[EW-2:0], 1'b0};
    assign rem_ge    = rem2 >= EW'(dur_eff);

    assign poly_pos = (PW'(r_a) << 2) + (PW'(r_a) << 1) + (PW'(ONE_Q) << 3) + (PW'(ONE_Q) << 1);
    assign poly_neg = (PW'(r_x) << 4) - PW'(r_x);
    assign poly     = (poly_pos > poly_neg) ? poly_pos - poly_neg : '0;
    assign smooth_b = (PW'(ONE_Q) << 1) + PW'(ONE_Q) - (PW'(r_x) << 1);

    always_comb begin
        mul_a = r_x;
        mul_b = PW'(r_x);
        unique case (i_cmd.op)
            OP_MUL_AX: begin
                mul_a = r_a;
                mul_b = PW'(r_x);
            end
            OP_SMOOTH: begin
                mul_a = r_a;
                mul_b = smooth_b;
            end
            OP_SMOOTHER: begin
                mul_a = r_b;
                mul_b = poly;
            end
            default: begin
                mul_a = r_x;
                mul_b = PW'(r_x);
            end
        endcase
    end

    assign mul_q = ((MW'(mul_a) * MW'(mul_b)) + MW'(HALF_Q)) >> FRAC_BITS;
    assign mul_c = (mul_q > MW'(ONE_Q)) ? ONE_Q : mul_q[QW-1:0];

    assign sine_sum = (QW+SAW+1)'(r_x) * (QW+SAW+1)'(SINE_TABLE_DEPTH) + (QW+SAW+1)'(HALF_Q);
    assign sine_idx = sine_sum[FRAC_BITS+SAW-1:FRAC_BITS];

    eip_ram #(
        .WIDTH (QW),
        .DEPTH (SINE_TABLE_DEPTH + 1)
    ) u_sine_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.op == OP_FILL),
        .i_waddr (r_fill),
        .i_wdata (SINE_ROM[r_fill]),
        .i_raddr (sine_idx),
        .o_rdata (sine_rdata)
    );

    assign v_s        = $signed({1'b0, r_x});
    assign w_s        = $signed({1'b0, ONE_Q - r_x});
    assign prod_end   = BW'(r_end_value) * BW'(v_s);
    assign prod_start = BW'(r_start_value) * BW'(w_s);
    assign acc_sum    = r_acc + AW'(HALF_Q);
    assign blend_val  = acc_sum[FRAC_BITS+31:FRAC_BITS];

    always_comb begin
        n_active  = r_active;
        n_elapsed = r_elapsed;
        n_held    = r_held;
        n_fin     = 1'b0;
        unique case (r_req)
            REQ_TICK: begin
                if (r_active) begin
                    n_held = blend_val;
                    if (el_ge_dur) begin
                        n_active  = 1'b0;
                        n_elapsed = '0;
                        n_fin     = 1'b1;
                    end else begin
                        n_elapsed = r_elapsed + EW'(r_step);
                    end
                end
            end
            REQ_START:   n_active  = 1'b1;
            REQ_STOP:    n_active  = 1'b0;
            REQ_RESTART: n_elapsed = '0;
            default:     n_active  = r_active;
        endcase
    end

    assign take_out = r_out_valid && !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_value <= '0;
            r_end_value   <= '0;
            r_duration    <= DW'(1);
            r_curve_mode  <= MODE_LINEAR;
            r_elapsed     <= '0;
            r_active      <= 1'b0;
            r_held        <= '0;
            r_fill        <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_START:    r_start_value <= i_cfg_data;
                    CFG_END:      r_end_value   <= i_cfg_data;
                    CFG_DURATION: r_duration    <= i_cfg_data[DW-1:0];
                    CFG_CURVE:    r_curve_mode  <= i_cfg_data[3:0];
                    default:      r_curve_mode  <= r_curve_mode;
                endcase
            end
            if (i_cmd.op == OP_FILL) begin
                r_fill <= r_fill + SAW'(1);
            end
            if (i_cmd.op == OP_COMMIT) begin
                r_active    <= n_active;
                r_elapsed   <= n_elapsed;
                r_held      <= n_held;
                r_out_valid <= 1'b1;
            end else if (take_out) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            OP_LATCH: begin
                r_req  <= t_req'(i_req_type);
                r_step <= i_step_time;
            end
            OP_DIV_INIT: begin
                r_rem <= r_elapsed;
                r_quo <= '0;
                r_cnt <= '0;
                r_x   <= ONE_Q;
            end
            OP_DIV_STEP: begin
                r_rem <= rem_ge ? rem2 - EW'(dur_eff) : rem2;
                r_quo <= {r_quo[FRAC_BITS-2:0], rem_ge};
                r_cnt <= r_cnt + CW'(1);
                r_x   <= {1'b0, r_quo[FRAC_BITS-2:0], rem_ge};
            end
            OP_MUL_XX:    r_a <= mul_q[QW-1:0];
            OP_MUL_AX:    r_b <= mul_q[QW-1:0];
            OP_SMOOTH:    r_x <= mul_c;
            OP_SMOOTHER:  r_x <= mul_c;
            OP_TAKE_A:    r_x <= r_a;
            OP_TAKE_B:    r_x <= r_b;
            OP_REFLECT:   r_x <= ONE_Q - r_x;
            OP_SINE_LOAD: r_x <= sine_rdata;
            OP_BLEND1:    r_p <= prod_end;
            OP_BLEND2:    r_acc <= AW'(r_p) + AW'(prod_start);
            OP_COMMIT: begin
                r_out_value <= n_held;
                r_running   <= n_active;
                r_finished  <= n_fin;
            end
            default: r_x <= r_x;
        endcase
    end

    assign o_status.tick_active = (r_req == REQ_TICK) && r_active;
    assign o_status.el_ge_dur   = el_ge_dur;
    assign o_status.div_last    = r_cnt == CW'(FRAC_BITS - 1);
    assign o_status.fill_last   = r_fill == SAW'(SINE_TABLE_DEPTH);
    assign o_status.out_busy    = r_out_valid && i_out_stall;
    assign o_status.curve_mode  = r_curve_mode;

    assign o_out_valid = r_out_valid;
    assign o_out_value = r_out_value;
    assign o_running   = r_running;
    assign o_finished  = r_finished;

endmodule

/* hw/rtl/eip_ctrl.sv */
// ----------------------------------------------------------------------------
// eip_ctrl
// Sequencer for table fill, request capture, division, curve steps and commit.
// ----------------------------------------------------------------------------
module eip_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  eip_pkg::t_status i_status,
    output eip_pkg::t_cmd    o_cmd
);
    import eip_pkg::*;

    typedef enum logic [7:0] {
        S_FILL     = 8'b0000_0001,
        S_IDLE     = 8'b0000_0010,
        S_DIV_INIT = 8'b0000_0100,
        S_DIV      = 8'b0000_1000,
        S_SHAPE    = 8'b0001_0000,
        S_BLEND1   = 8'b0010_0000,
        S_BLEND2   = 8'b0100_0000,
        S_COMMIT   = 8'b1000_0000
    } t_state;

    t_state     r_state;
    t_state     n_state;
    logic [2:0] r_pc;
    logic [2:0] n_pc;
    t_op        step_op;

    assign step_op = shape_op(i_status.curve_mode, r_pc);

    always_comb begin
        n_state  = r_state;
        n_pc     = r_pc;
        o_cmd.op = OP_NONE;
        unique case (r_state)
            S_FILL: begin
                o_cmd.op = OP_FILL;
                if (i_status.fill_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = OP_LATCH;
                    n_state  = S_DIV_INIT;
                end
            end
            S_DIV_INIT: begin
                n_pc = '0;
                if (!i_status.tick_active) begin
                    n_state = S_COMMIT;
                end else begin
                    o_cmd.op = OP_DIV_INIT;
                    n_state  = i_status.el_ge_dur ? S_SHAPE : S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.op = OP_DIV_STEP;
                if (i_status.div_last) begin
                    n_state = S_SHAPE;
                end
            end
            S_SHAPE: begin
                o_cmd.op = step_op;
                n_pc     = r_pc + 3'd1;
                if (step_op == OP_END) begin
                    n_state = S_BLEND1;
                end
            end
            S_BLEND1: begin
                o_cmd.op = OP_BLEND1;
                n_state  = S_BLEND2;
            end
            S_BLEND2: begin
                o_cmd.op = OP_BLEND2;
                n_state  = S_COMMIT;
            end
            S_COMMIT: begin
                if (!i_status.out_busy) begin
                    o_cmd.op = OP_COMMIT;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_FILL;
            r_pc    <= '0;
        end else begin
            r_state <= n_state;
            r_pc    <= n_pc;
        end
    end

    assign o_in_stall = r_state != S_IDLE;

endmodule

/* tb/sv/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the eased_interpolator tween channel.
// ----------------------------------------------------------------------------
// A queue of requests feeds a driver, and a monitor checks every result
// against a bit-exact predictor of the tween arithmetic. The registers are
// rewritten between phases while the block is idle. Both channels idle in
// random bursts, and the receiver once stalls for a long stretch.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import eip_pkg::*;

    localparam longint unsigned UNIT = 64'd1 << 16;
    localparam longint unsigned HALF = 64'd1 << 15;
    localparam int ROM_N = 1024;

    typedef struct {
        t_req        req;
        logic [15:0] step;
    } t_request;

    typedef struct {
        logic [31:0] value;
        logic        running;
        logic        finished;
    } t_tween_out;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_in_valid = 1'b0;
    logic              o_in_stall;
    logic [1:0]        i_req_type = 2'd0;
    logic [15:0]       i_step_time = 16'd0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    logic signed [31:0] o_out_value;
    logic              o_running;
    logic              o_finished;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic [IW-1:0]     i_cfg_index = '0;
    logic [31:0]       i_cfg_data = 32'd0;

    eased_interpolator dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Predictor state and registers.
    logic [31:0] p_start, p_end, p_held;
    logic [23:0] p_duration;
    logic [3:0]  p_curve;
    logic [24:0] p_elapsed;
    logic        p_active;
    longint unsigned sine_tab [0:ROM_N];

    t_request   pending_reqs [$];
    t_tween_out expected_outs [$];
    int n_offered = 0;
    int n_accepted = 0;
    int n_errors = 0;
    bit quiet = 1'b0;
    int hold_asked = 0;
    int hold_served = 0;

    function automatic longint unsigned qmul(longint unsigned a, longint unsigned b);
        return (a * b + HALF) >> 16;
    endfunction

    function automatic longint unsigned qsat(longint unsigned a);
        return (a > UNIT) ? UNIT : a;
    endfunction

    function automatic longint unsigned ease_smooth(longint unsigned x);
        return qsat(qmul(qmul(x, x), 3 * UNIT - 2 * x));
    endfunction

    function automatic longint unsigned ease_smoother(longint unsigned x);
        longint unsigned x2, x3, pos, neg;
        x2 = qmul(x, x);
        x3 = qmul(x2, x);
        pos = 6 * x2 + 10 * UNIT;
        neg = 15 * x;
        return qsat(qmul(x3, (pos > neg) ? pos - neg : 64'd0));
    endfunction

    function automatic longint unsigned ease(longint unsigned x, logic [3:0] mode);
        longint unsigned r;
        case (mode)
            MODE_SMOOTH:       return ease_smooth(x);
            MODE_SMOOTHER:     return ease_smoother(x);
            MODE_DBL_SMOOTH:   return ease_smooth(ease_smooth(x));
            MODE_DBL_SMOOTHER: return ease_smoother(ease_smoother(x));
            MODE_ACCEL:        return qsat(qmul(x, x));
            MODE_DECEL: begin
                r = UNIT - x;
                return qsat(UNIT - qsat(qmul(r, r)));
            end
            MODE_CUBE_ACCEL:   return qsat(qmul(qmul(x, x), x));
            MODE_CUBE_DECEL: begin
                r = UNIT - x;
                return qsat(UNIT - qsat(qmul(qmul(r, r), r)));
            end
            MODE_SINE: begin
                r = (x * ROM_N + HALF) >> 16;
                if (r > ROM_N) begin
                    r = ROM_N;
                end
                return sine_tab[r];
            end
            default: return x;
        endcase
    endfunction

    function automatic logic [31:0] mix(longint unsigned v);
        longint acc;
        acc = longint'($signed(p_end)) * longint'(v)
            + longint'($signed(p_start)) * longint'(UNIT - v);
        return 32'((acc + longint'(HALF)) >>> 16);
    endfunction

    function automatic t_tween_out tween_step(t_request r);
        t_tween_out o;
        longint unsigned dur, el, p;
        o.finished = 1'b0;
        case (r.req)
            REQ_TICK: begin
                if (p_active) begin
                    dur = (p_duration == 0) ? 64'd1 : 64'(p_duration);
                    el = 64'(p_elapsed);
                    p = ((el < dur ? el : dur) * UNIT) / dur;
                    p_held = mix(ease(p, p_curve));
                    if (el >= dur) begin
                        p_active = 1'b0;
                        p_elapsed = '0;
                        o.finished = 1'b1;
                    end else begin
                        p_elapsed = 25'(el + r.step);
                    end
                end
            end
            REQ_START: p_active = 1'b1;
            REQ_STOP:  p_active = 1'b0;
            default:   p_elapsed = '0;
        endcase
        o.value = p_held;
        o.running = p_active;
        return o;
    endfunction

    // Driver: next request at the falling edge once the last one transferred.
    int gap = 0;
    always @(negedge i_clk) begin
        t_request r;
        if (!i_in_valid || n_accepted == n_offered) begin
            if (gap > 0) begin
                gap--;
                i_in_valid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
                r = pending_reqs.pop_front();
                i_req_type <= r.req;
                i_step_time <= r.step;
                i_in_valid <= 1'b1;
                n_offered++;
                if (!quiet && $urandom_range(0, 5) == 0) begin
                    gap = $urandom_range(1, 14);
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Receiver stall: random bursts, plus one long hold on request.
    int stall_left = 0;
    always @(negedge i_clk) begin
        if (hold_served < hold_asked) begin
            hold_served++;
            stall_left = 300;
        end
        if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 13);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // Input transfers feed the predictor; output transfers are checked.
    always @(posedge i_clk) begin
        t_request r;
        t_tween_out e;
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            r.req = t_req'(i_req_type);
            r.step = i_step_time;
            expected_outs.push_back(tween_step(r));
            n_accepted++;
        end
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_outs.size() == 0) begin
                $error("unexpected result transfer, value %h", o_out_value);
                n_errors++;
            end else begin
                e = expected_outs.pop_front();
                if (o_out_value !== e.value) begin
                    $error("out_value: expected %h, actual %h", e.value, o_out_value);
                    n_errors++;
                end
                if (o_running !== e.running) begin
                    $error("running: expected %b, actual %b", e.running, o_running);
                    n_errors++;
                end
                if (o_finished !== e.finished) begin
                    $error("finished: expected %b, actual %b", e.finished, o_finished);
                    n_errors++;
                end
            end
        end
    end

    task automatic write_reg(logic [IW-1:0] idx, logic [31:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_START:    p_start = data;
            CFG_END:      p_end = data;
            CFG_DURATION: p_duration = data[23:0];
            default:      p_curve = data[3:0];
        endcase
    endtask

    task automatic configure(logic [31:0] s, logic [31:0] e, logic [31:0] d, logic [31:0] c);
        write_reg(CFG_START, s);
        write_reg(CFG_END, e);
        write_reg(CFG_DURATION, d);
        write_reg(CFG_CURVE, c);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        wait (pending_reqs.size() == 0 && n_accepted == n_offered
              && expected_outs.size() == 0);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic push_req(t_req q, logic [15:0] s);
        t_request r;
        r.req = q;
        r.step = s;
        pending_reqs.push_back(r);
    endtask

    initial begin
        int total;
        int dur;
        int ticks;
        longint unsigned th, th2, term, pos, neg, s, e;

        for (int i = 0; i <= ROM_N; i++) begin
            th = 64'd1686629713 * 64'(i) / ROM_N;
            th2 = (th * th) >> 30;
            term = th;
            pos = th;
            neg = 0;
            for (int k = 1; k <= 9; k++) begin
                term = ((term * th2) >> 30) / (64'(2 * k) * 64'(2 * k + 1));
                if (k % 2 == 1) begin
                    neg += term;
                end else begin
                    pos += term;
                end
            end
            s = (pos > neg) ? pos - neg : 64'd0;
            e = ((s << 16) + (64'd1 << 29)) >> 30;
            sine_tab[i] = qsat(e);
        end
        p_start = 0;
        p_end = 0;
        p_duration = 1;
        p_curve = MODE_LINEAR;
        p_elapsed = 0;
        p_active = 0;
        p_held = 0;

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: extreme values, every request, ticks while stopped.
        configure(32'h7FFF_FFFF, 32'h8000_0000, 32'd1, 32'(MODE_LINEAR));
        push_req(REQ_TICK, 16'hFFFF);
        push_req(REQ_STOP, 16'h0000);
        push_req(REQ_RESTART, 16'hFFFF);
        push_req(REQ_START, 16'h0000);
        push_req(REQ_TICK, 16'h0000);
        push_req(REQ_TICK, 16'h0000);
        push_req(REQ_TICK, 16'hFFFF);
        push_req(REQ_TICK, 16'hFFFF);
        push_req(REQ_START, 16'h5555);
        push_req(REQ_TICK, 16'hAAAA);
        push_req(REQ_RESTART, 16'h0000);
        push_req(REQ_TICK, 16'h0000);
        push_req(REQ_STOP, 16'h0000);
        push_req(REQ_TICK, 16'h0001);
        drain();
        configure(32'h8000_0000, 32'h7FFF_FFFF, 32'hFF00_0000, 32'(MODE_SINE));
        push_req(REQ_START, 16'h0000);
        push_req(REQ_TICK, 16'h0000);
        push_req(REQ_TICK, 16'h0000);
        drain();
        configure(32'h0001_0000, 32'hFFFF_0000, 32'h00FF_FFFF, 32'd15);
        push_req(REQ_START, 16'h0000);
        for (int i = 0; i < 6; i++) begin
            push_req(REQ_TICK, 16'hFFFF);
        end
        drain();
        // Lowering the duration below the elapsed time ends the run next tick.
        write_reg(CFG_DURATION, 32'd3);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        push_req(REQ_TICK, 16'h0000);
        push_req(REQ_TICK, 16'h0000);
        total = 26;
        drain();

        // Random phases of whole tweens, with some noise and broken runs.
        for (int ph = 0; total < 450; ph++) begin
            case ($urandom_range(0, 9))
                0:       dur = 16777215;
                1:       dur = $urandom_range(1, 16777215);
                default: dur = $urandom_range(1, 400);
            endcase
            configure($urandom, $urandom, {8'($urandom_range(0, 255)), 24'(dur)},
                      (ph < 10) ? ph : (($urandom_range(0, 4) == 0)
                          ? $urandom_range(10, 15) : $urandom_range(0, 9)));
            if (ph == 3) begin
                hold_asked++;
            end
            if (total > 390) begin
                quiet = 1'b1;
            end
            ticks = $urandom_range(3, 14);
            push_req(REQ_START, 16'($urandom));
            for (int i = 0; i <= ticks + 1; i++) begin
                if ($urandom_range(0, 9) == 0) begin
                    push_req(t_req'($urandom_range(0, 3)), 16'($urandom));
                end else if (dur > 65535 * 8) begin
                    push_req(REQ_TICK, 16'($urandom));
                end else begin
                    push_req(REQ_TICK, 16'((dur + ticks - 1) / ticks
                                           + $urandom_range(0, 2)));
                end
                total++;
            end
            total++;
            drain();
        end

        if (n_errors == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("testbench NOT OK");
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/eip_pkg.sv
hw/rtl/eip_ram.sv
hw/rtl/eip_datapath.sv
hw/rtl/eip_ctrl.sv
hw/rtl/eased_interpolator.sv
tb/sv/testbench.sv
